[hdl/rgb_led_strip_frame_controller_defines.svh]
// Assertion macros for the RGB LED strip frame controller.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef RGB_LED_STRIP_FRAME_CONTROLLER_DEFINES_SVH
`define RGB_LED_STRIP_FRAME_CONTROLLER_DEFINES_SVH

// check a property on every rising clock edge outside reset
`define RGBL_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rgbl assertion failed");

// check a property that must also hold during reset
`define RGBL_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("rgbl assertion failed");

`endif

[hdl/rgbl_pkg.sv]
// Shared constants, codes and control types of the RGB LED strip frame controller.
// No dependencies.
package rgbl_pkg;

  localparam int LED_COUNT = 16;
  localparam int BAR_STEPS = 2;

  localparam int PIX_W  = 4;
  localparam int CH_W   = 2;
  localparam int COL_W  = 8;
  localparam int SYM_W  = 8;
  localparam int WORD_W = 8 * SYM_W;
  localparam int CMD_W  = 3;
  localparam int IDX_W  = 8;
  localparam int PCT_W  = 8;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int BAR_W  = 16;

  localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(100);

  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_WORD = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  localparam logic REG_HIGH = 1'b0;
  localparam logic REG_LOW  = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_SEND = 3'd0,
    CMD_OFF  = 3'd1,
    CMD_MOVE = 3'd2,
    CMD_TWO  = 3'd3,
    CMD_BAR  = 3'd4
  } cmd_e;

  typedef enum logic [CH_W-1:0] {
    CH_GREEN = 2'd0,
    CH_RED   = 2'd1,
    CH_BLUE  = 2'd2
  } ch_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_SEND,
    ST_ACK
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic fill_wr;
    logic emit_word;
    logic emit_ack;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] in_cmd;
    logic             in_pct_bad;
    logic [CMD_W-1:0] cmd;
    logic             pix_last;
    logic             word_last;
    logic             out_free;
  } dp_sts_t;

endpackage

[hdl/rgbl_regs.sv]
// Configuration registers (high and low line symbols) behind the APB-style port.
// Depends on rgbl_pkg.
module rgbl_regs import rgbl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [SYM_W-1:0]  high_sym_o,
  output logic [SYM_W-1:0]  low_sym_o
);

  logic [SYM_W-1:0] high_q, high_d;
  logic [SYM_W-1:0] low_q, low_d;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    high_d = high_q;
    low_d  = low_q;
    if (wr_en) begin
      case (paddr[2])
        REG_HIGH: high_d = pwdata[SYM_W-1:0];
        REG_LOW:  low_d  = pwdata[SYM_W-1:0];
        default:  high_d = high_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_q <= '0;
      low_q  <= '0;
    end else begin
      high_q <= high_d;
      low_q  <= low_d;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_HIGH: prdata = {{(DATA_W-SYM_W){1'b0}}, high_q};
      REG_LOW:  prdata = {{(DATA_W-SYM_W){1'b0}}, low_q};
      default:  prdata = '0;
    endcase
  end

  assign high_sym_o = high_q;
  assign low_sym_o  = low_q;

endmodule

[hdl/rgbl_ctrl.sv]
// Command sequencer: accepts items, runs the frame rewrite sweep, the send
// sweep and the acknowledge. Depends on rgbl_pkg.
module rgbl_ctrl import rgbl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          case (sts_i.in_cmd)
            CMD_SEND: state_d = ST_SEND;
            CMD_OFF, CMD_MOVE, CMD_TWO: state_d = ST_FILL;
            CMD_BAR: state_d = sts_i.in_pct_bad ? ST_ACK : ST_FILL;
            default: state_d = ST_ACK;
          endcase
        end
      end
      ST_FILL: begin
        cmd_o.fill_wr = 1'b1;
        if (sts_i.pix_last) begin
          state_d = (sts_i.cmd == CMD_OFF) ? ST_SEND : ST_ACK;
        end
      end
      ST_SEND: begin
        if (sts_i.out_free) begin
          cmd_o.emit_word = 1'b1;
          if (sts_i.word_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_ACK: begin
        if (sts_i.out_free) begin
          cmd_o.emit_ack = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[hdl/rgbl_dp.sv]
// Datapath: command payload, frame store, moving index, sweep counters,
// pixel rewrite logic, symbol encoder and output register. Depends on rgbl_pkg.
module rgbl_dp import rgbl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_sts_t            sts_o,
  input  logic [SYM_W-1:0]   high_sym_i,
  input  logic [SYM_W-1:0]   low_sym_i,
  input  logic [CMD_W-1:0]   in_command_i,
  input  logic [COL_W-1:0]   in_red_i,
  input  logic [COL_W-1:0]   in_green_i,
  input  logic [COL_W-1:0]   in_blue_i,
  input  logic [IDX_W-1:0]   in_index_a_i,
  input  logic [COL_W-1:0]   in_red_b_i,
  input  logic [COL_W-1:0]   in_green_b_i,
  input  logic [COL_W-1:0]   in_blue_b_i,
  input  logic [IDX_W-1:0]   in_index_b_i,
  input  logic [PCT_W-1:0]   in_percent_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic               out_kind_o,
  output logic [WORD_W-1:0]  out_symbols_o,
  output logic [PIX_W-1:0]   out_pixel_o,
  output logic [CH_W-1:0]    out_channel_o,
  output logic               out_status_o,
  output logic               out_last_o
);

  function automatic logic [WORD_W-1:0] encode_byte(logic [COL_W-1:0] v,
                                                    logic [SYM_W-1:0] hi,
                                                    logic [SYM_W-1:0] lo);
    logic [WORD_W-1:0] w;
    w = '0;
    for (int i = 0; i < COL_W; i++) begin
      w[SYM_W*i +: SYM_W] = v[i] ? hi : lo;
    end
    return w;
  endfunction

  // command payload
  logic [CMD_W-1:0] cmd_q;
  logic [COL_W-1:0] red_q, green_q, blue_q, red_b_q, green_b_q, blue_b_q;
  logic [IDX_W-1:0] idx_a_q, idx_b_q;
  logic [PCT_W-1:0] pct_q;

  // frame and counters
  logic [COL_W-1:0] fr_red_q   [LED_COUNT];
  logic [COL_W-1:0] fr_green_q [LED_COUNT];
  logic [COL_W-1:0] fr_blue_q  [LED_COUNT];
  logic [PIX_W-1:0] move_q, move_d;
  logic [PIX_W-1:0] pix_q, pix_d;
  logic [CH_W-1:0]  ch_q, ch_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic              out_kind_q;
  logic [WORD_W-1:0] out_sym_q;
  logic [PIX_W-1:0]  out_pix_q;
  logic [CH_W-1:0]   out_ch_q;
  logic              out_status_q;
  logic              out_last_q;

  logic              pix_last, word_last, pct_bad, out_free;
  logic [COL_W-1:0]  px_red, px_green, px_blue, rd_byte;
  logic [IDX_W-1:0]  pix_ext;
  logic [BAR_W-1:0]  bar_level, bar_full_th, bar_half_th;
  logic              bar_full, bar_half;

  assign pix_last  = (pix_q == PIX_W'(LED_COUNT - 1));
  assign word_last = pix_last && (ch_q == CH_BLUE);
  assign pct_bad   = (pct_q > PCT_MAX);
  assign out_free  = !out_valid_q || out_ready_i;
  assign pix_ext   = IDX_W'(pix_q);

  assign sts_o.in_cmd     = in_command_i;
  assign sts_o.in_pct_bad = (in_percent_i > PCT_MAX);
  assign sts_o.cmd        = cmd_q;
  assign sts_o.pix_last   = pix_last;
  assign sts_o.word_last  = word_last;
  assign sts_o.out_free   = out_free;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q     <= in_command_i;
      red_q     <= in_red_i;
      green_q   <= in_green_i;
      blue_q    <= in_blue_i;
      idx_a_q   <= in_index_a_i;
      red_b_q   <= in_red_b_i;
      green_b_q <= in_green_b_i;
      blue_b_q  <= in_blue_b_i;
      idx_b_q   <= in_index_b_i;
      pct_q     <= in_percent_i;
    end
  end

  // bargraph: pixel i is full when S*L*pct >= 100*S*(i+1), half when
  // S*L*pct >= 100*(S*i+1) and not full
  assign bar_level   = BAR_W'(pct_q) * BAR_W'(BAR_STEPS * LED_COUNT);
  assign bar_full_th = BAR_W'(100 * BAR_STEPS) * (BAR_W'(pix_q) + BAR_W'(1));
  assign bar_half_th = BAR_W'(100) * (BAR_W'(BAR_STEPS) * BAR_W'(pix_q) + BAR_W'(1));
  assign bar_full    = (bar_level >= bar_full_th);
  assign bar_half    = !bar_full && (bar_level >= bar_half_th);

  always_comb begin
    px_red   = '0;
    px_green = '0;
    px_blue  = '0;
    case (cmd_q)
      CMD_MOVE: begin
        if (pix_q == move_q) begin
          px_red   = red_q;
          px_green = green_q;
          px_blue  = blue_q;
        end
      end
      CMD_TWO: begin
        if (pix_ext == idx_b_q) begin
          px_red   = red_b_q;
          px_green = green_b_q;
          px_blue  = blue_b_q;
        end else if (pix_ext == idx_a_q) begin
          px_red   = red_q;
          px_green = green_q;
          px_blue  = blue_q;
        end
      end
      CMD_BAR: begin
        if (bar_full) begin
          px_red   = red_q;
          px_green = green_q;
          px_blue  = blue_q;
        end else if (bar_half) begin
          px_red   = red_q >> 1;
          px_green = green_q >> 1;
          px_blue  = blue_q >> 1;
        end
      end
      default: px_red = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LED_COUNT; i++) begin
        fr_red_q[i]   <= '0;
        fr_green_q[i] <= '0;
        fr_blue_q[i]  <= '0;
      end
    end else if (cmd_i.fill_wr) begin
      fr_red_q[pix_q]   <= px_red;
      fr_green_q[pix_q] <= px_green;
      fr_blue_q[pix_q]  <= px_blue;
    end
  end

  always_comb begin
    pix_d  = pix_q;
    ch_d   = ch_q;
    move_d = move_q;
    if (cmd_i.load) begin
      pix_d = '0;
      ch_d  = CH_GREEN;
    end else if (cmd_i.fill_wr) begin
      pix_d = pix_last ? '0 : pix_q + PIX_W'(1);
      if (pix_last && (cmd_q == CMD_MOVE)) begin
        move_d = (move_q == PIX_W'(LED_COUNT - 1)) ? '0 : move_q + PIX_W'(1);
      end
    end else if (cmd_i.emit_word) begin
      if (ch_q == CH_BLUE) begin
        ch_d  = CH_GREEN;
        pix_d = pix_last ? '0 : pix_q + PIX_W'(1);
      end else begin
        ch_d = ch_q + CH_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q  <= '0;
      ch_q   <= CH_GREEN;
      move_q <= '0;
    end else begin
      pix_q  <= pix_d;
      ch_q   <= ch_d;
      move_q <= move_d;
    end
  end

  always_comb begin
    case (ch_q)
      CH_GREEN: rd_byte = fr_green_q[pix_q];
      CH_RED:   rd_byte = fr_red_q[pix_q];
      CH_BLUE:  rd_byte = fr_blue_q[pix_q];
      default:  rd_byte = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit_word || cmd_i.emit_ack) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_word) begin
      out_kind_q   <= KIND_WORD;
      out_sym_q    <= encode_byte(rd_byte, high_sym_i, low_sym_i);
      out_pix_q    <= pix_q;
      out_ch_q     <= ch_q;
      out_status_q <= STATUS_OK;
      out_last_q   <= word_last;
    end else if (cmd_i.emit_ack) begin
      out_kind_q   <= KIND_ACK;
      out_sym_q    <= '0;
      out_pix_q    <= '0;
      out_ch_q     <= CH_GREEN;
      out_status_q <= ((cmd_q == CMD_BAR) && pct_bad) ? STATUS_RANGE : STATUS_OK;
      out_last_q   <= 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_kind_o    = out_kind_q;
  assign out_symbols_o = out_sym_q;
  assign out_pixel_o   = out_pix_q;
  assign out_channel_o = out_ch_q;
  assign out_status_o  = out_status_q;
  assign out_last_o    = out_last_q;

endmodule

[hdl/rgb_led_strip_frame_controller.sv]
// RGB LED strip frame controller: top level joining registers, sequencer and datapath.
// Depends on rgbl_pkg, rgbl_regs, rgbl_ctrl, rgbl_dp and the assertion macro header.
//
// Usage: a command item enters on the in_* valid/ready channel; results leave on
// the out_* valid/ready channel. The APB-style port sets the high and low line
// symbols (register 0 at address 0, register 1 at address 4); write it only while idle.
// One command is worked on at a time; in_ready_o is high only between commands.
// Send: 48 symbol words, one per cycle while the receiver takes them; the first
// word passes the sequencer state register, then the output register.
// Off: a clear sweep of all 16 pixels of the frame, then the 48-word send.
// Moving point, two points, bargraph: a rewrite sweep of all 16 pixels, one pixel per
// cycle through the frame write port, then one acknowledge.
// A bargraph percent above 100 and an unknown command go to the acknowledge with no sweep.
// The frame read port gives one pixel channel per cycle, which sets the send rate.
// The output register holds a result while the receiver stalls; the sweep waits
// and no result is lost. An acknowledge may sit there while the next command enters.
// Reset clears the frame, the moving index, both symbol registers and out_valid_o.
module rgb_led_strip_frame_controller import rgbl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CMD_W-1:0]  in_command_i,
  input  logic [COL_W-1:0]  in_red_i,
  input  logic [COL_W-1:0]  in_green_i,
  input  logic [COL_W-1:0]  in_blue_i,
  input  logic [IDX_W-1:0]  in_index_a_i,
  input  logic [COL_W-1:0]  in_red_b_i,
  input  logic [COL_W-1:0]  in_green_b_i,
  input  logic [COL_W-1:0]  in_blue_b_i,
  input  logic [IDX_W-1:0]  in_index_b_i,
  input  logic [PCT_W-1:0]  in_percent_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              out_kind_o,
  output logic [WORD_W-1:0] out_symbols_o,
  output logic [PIX_W-1:0]  out_pixel_o,
  output logic [CH_W-1:0]   out_channel_o,
  output logic              out_status_o,
  output logic              out_last_o
);

`include "rgb_led_strip_frame_controller_defines.svh"

  logic [SYM_W-1:0] high_sym, low_sym;
  dp_cmd_t          dp_cmd;
  dp_sts_t          dp_sts;

  rgbl_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .high_sym_o (high_sym),
    .low_sym_o  (low_sym)
  );

  rgbl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  rgbl_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .sts_o         (dp_sts),
    .high_sym_i    (high_sym),
    .low_sym_i     (low_sym),
    .in_command_i  (in_command_i),
    .in_red_i      (in_red_i),
    .in_green_i    (in_green_i),
    .in_blue_i     (in_blue_i),
    .in_index_a_i  (in_index_a_i),
    .in_red_b_i    (in_red_b_i),
    .in_green_b_i  (in_green_b_i),
    .in_blue_b_i   (in_blue_b_i),
    .in_index_b_i  (in_index_b_i),
    .in_percent_i  (in_percent_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .out_kind_o    (out_kind_o),
    .out_symbols_o (out_symbols_o),
    .out_pixel_o   (out_pixel_o),
    .out_channel_o (out_channel_o),
    .out_status_o  (out_status_o),
    .out_last_o    (out_last_o)
  );

  `RGBL_ASSERT(a_busy_after_transfer, (in_valid_i && in_ready_o) |=> !in_ready_o)
  `RGBL_ASSERT(a_last_word_is_final_channel,
    (out_valid_o && out_kind_o == KIND_WORD && out_last_o) |->
      (out_pixel_o == PIX_W'(LED_COUNT - 1) && out_channel_o == CH_BLUE))
  `RGBL_ASSERT(a_ack_is_last, (out_valid_o && out_kind_o == KIND_ACK) |-> out_last_o)
  `RGBL_ASSERT_ALWAYS(a_no_output_in_reset, !rst_ni |=> !out_valid_o || rst_ni)

endmodule
